// ===== design/mtp_pkg.sv =====
// shared types and codes of the microbatch task picker
`timescale 1ns / 1ps

package mtp_pkg;

  // opcodes
  localparam logic [2:0] OP_ACT  = 3'd0;
  localparam logic [2:0] OP_GRAD = 3'd1;
  localparam logic [2:0] OP_WAIT = 3'd2;
  localparam logic [2:0] OP_DONE = 3'd3;
  localparam logic [2:0] OP_PICK = 3'd4;

  // status codes
  localparam logic [2:0] STS_OK        = 3'd0;
  localparam logic [2:0] STS_RANGE     = 3'd1;
  localparam logic [2:0] STS_STEP      = 3'd2;
  localparam logic [2:0] STS_WAITING   = 3'd3;
  localparam logic [2:0] STS_UPDATE    = 3'd4;
  localparam logic [2:0] STS_BAD_CFG   = 3'd5;

  // phases
  localparam logic [1:0] PH_FWD = 2'd0;
  localparam logic [1:0] PH_BWD = 2'd1;

  // configuration register indexes
  localparam logic [2:0] CFG_NUM_STAGES  = 3'd0;
  localparam logic [2:0] CFG_STAGE_INDEX = 3'd1;
  localparam logic [2:0] CFG_NUM_MB      = 3'd2;
  localparam logic [2:0] CFG_FWD_LIMIT   = 3'd3;
  localparam logic [2:0] CFG_BWD_LIMIT   = 3'd4;

  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DONE
  } state_t;

  // per-microbatch state word
  typedef struct packed {
    logic        act;
    logic        grad;
    logic        fwait;
    logic        bwait;
    logic        ffin;
    logic        bfin;
    logic [15:0] fcnt;
    logic [15:0] bcnt;
  } entry_t;

  // stage settings the evaluation unit needs
  typedef struct packed {
    logic        stage0;
    logic        last_stage;
    logic [15:0] fwd_limit;
    logic [15:0] bwd_limit;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        found;
    logic        pick_phase;
    logic [5:0]  pick_microbatch;
    logic [15:0] pick_step;
    logic        fwd_finished_flag;
    logic        bwd_finished_flag;
  } res_t;

endpackage

// ===== design/mtp_if.sv =====
// valid/ready channel interfaces for items and results
`timescale 1ns / 1ps

interface mtp_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [5:0]  microbatch;
  logic [1:0]  phase;
  logic [15:0] step_index;
  logic        waiting;

  modport source (output valid, opcode, microbatch, phase, step_index, waiting,
                  input ready);
  modport sink   (input valid, opcode, microbatch, phase, step_index, waiting,
                  output ready);
endinterface

interface mtp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        found;
  logic        pick_phase;
  logic [5:0]  pick_microbatch;
  logic [15:0] pick_step;
  logic        fwd_finished_flag;
  logic        bwd_finished_flag;

  modport source (output valid, status, found, pick_phase, pick_microbatch, pick_step,
                  fwd_finished_flag, bwd_finished_flag, input ready);
  modport sink   (input valid, status, found, pick_phase, pick_microbatch, pick_step,
                  fwd_finished_flag, bwd_finished_flag, output ready);
endinterface

// ===== design/mtp_store.sv =====
// per-microbatch state memory, one write port and one registered read port
`timescale 1ns / 1ps

module mtp_store
  import mtp_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/mtp_eval.sv =====
// shared evaluation unit: runnable checks and the update of one state word
`timescale 1ns / 1ps

module mtp_eval
  import mtp_pkg::*;
(
  input  entry_t      ent,
  input  cfg_t        cfgv,
  input  logic [2:0]  opcode,
  input  logic [1:0]  phase,
  input  logic [15:0] step_index,
  input  logic        waiting,
  output entry_t      ent_nxt,
  output logic [2:0]  status,
  output logic        fwd_run,
  output logic        bwd_run
);

  logic [15:0] cnt;
  logic [15:0] cnt_inc;
  logic [15:0] lim;
  logic        wt;

  assign fwd_run = (ent.act || cfgv.stage0) && !ent.ffin && !ent.fwait &&
                   (ent.fcnt < cfgv.fwd_limit);
  assign bwd_run = ent.ffin && (cfgv.last_stage || ent.grad) && !ent.bfin &&
                   !ent.bwait && (ent.bcnt < cfgv.bwd_limit);

  assign cnt     = phase[0] ? ent.bcnt : ent.fcnt;
  assign wt      = phase[0] ? ent.bwait : ent.fwait;
  assign lim     = phase[0] ? cfgv.bwd_limit : cfgv.fwd_limit;
  assign cnt_inc = (cnt != CNT_MAX) ? cnt + 16'd1 : cnt;

  always_comb begin
    ent_nxt = ent;
    status  = STS_OK;
    priority if (opcode == OP_ACT) begin
      ent_nxt.act = 1'b1;
    end else if (opcode == OP_GRAD) begin
      ent_nxt.grad = 1'b1;
    end else if (opcode == OP_WAIT || opcode == OP_DONE) begin
      priority if (phase != PH_FWD && phase != PH_BWD) begin
        status = STS_UPDATE;
      end else if (step_index != cnt) begin
        status = STS_STEP;
      end else if (opcode == OP_WAIT) begin
        if (phase[0]) ent_nxt.bwait = waiting;
        else          ent_nxt.fwait = waiting;
      end else if (wt) begin
        status = STS_WAITING;
      end else begin
        if (phase[0]) begin
          ent_nxt.bcnt = cnt_inc;
          if (cnt_inc >= lim) ent_nxt.bfin = 1'b1;
        end else begin
          ent_nxt.fcnt = cnt_inc;
          if (cnt_inc >= lim) begin
            ent_nxt.ffin = 1'b1;
            // last stage makes its own gradient
            if (cfgv.last_stage) ent_nxt.grad = 1'b1;
          end
        end
      end
    end else begin
      // reserved opcodes change nothing
      ent_nxt = ent;
    end
  end

endmodule

// ===== design/microbatch_task_picker_unit.sv =====
// top level of the microbatch task picker: sequencer, config and result register
`timescale 1ns / 1ps

// Task scheduler of one pipeline stage. Per-microbatch flags and step counters live in
// one memory with a single read port; after reset a clearing pass writes every entry
// to zero in turn, with in_ch.ready low. Each item is then accepted in ST_IDLE and
// goes either through the read-and-update state ST_EXEC (all operations but pick on
// an in-range microbatch), or through a scan for pick that reads one microbatch per
// cycle until one is runnable or none is left. Bad config and out-of-range items
// finish in the accept cycle. ST_DONE then moves the result into the output register
// once that register is free, and the next item is accepted while that result waits.
// Configuration is written through cfg_we, cfg_index and cfg_wdata; the user must do
// so only while no item is in flight, and the block itself does not enforce this.
module microbatch_task_picker_unit
  import mtp_pkg::*;
#(
  parameter int MAX_MICROBATCHES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  mtp_in_if.sink      in_ch,
  mtp_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int AW = (MAX_MICROBATCHES > 1) ? $clog2(MAX_MICROBATCHES) : 1;
  localparam int CW = $clog2(MAX_MICROBATCHES + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_MICROBATCHES - 1);

  state_t state_r, state_nxt;

  logic [8:0]  num_stages_r;
  logic [7:0]  stage_index_r;
  logic [6:0]  num_mb_r;
  logic [15:0] fwd_limit_r;
  logic [15:0] bwd_limit_r;

  logic [2:0]  op_r;
  logic [5:0]  mb_r;
  logic [1:0]  phase_r;
  logic [15:0] k_r;
  logic        wait_r;

  logic [AW-1:0] clr_idx_r;
  logic [CW-1:0] issue_idx_r;
  logic [CW-1:0] rd_idx_r;
  logic          rd_pend_r;

  res_t res_r;
  res_t res_acc;
  res_t out_r;
  logic out_valid_r;

  cfg_t   cfgv;
  logic   cfg_ok;
  logic   accept;
  logic   in_range;
  logic   issuing;
  logic   scan_hit;
  logic   scan_miss;
  logic   out_load;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_rdata;

  entry_t     ent_nxt;
  logic [2:0] ev_status;
  logic       fwd_run;
  logic       bwd_run;

  logic [31:0] in_mb_ext;
  logic [31:0] mb_r_ext;
  logic [31:0] issue_ext;
  logic [31:0] rd_idx_ext;

  assign in_mb_ext  = 32'(in_ch.microbatch);
  assign mb_r_ext   = 32'(mb_r);
  assign issue_ext  = 32'(issue_idx_r);
  assign rd_idx_ext = 32'(rd_idx_r);

  assign cfgv.stage0     = (stage_index_r == 8'd0);
  assign cfgv.last_stage = (({1'b0, stage_index_r} + 9'd1) == num_stages_r);
  assign cfgv.fwd_limit  = fwd_limit_r;
  assign cfgv.bwd_limit  = bwd_limit_r;

  assign cfg_ok = (num_stages_r != 9'd0) && ({1'b0, stage_index_r} < num_stages_r) &&
                  (num_mb_r != 7'd0) && (32'(num_mb_r) <= 32'(MAX_MICROBATCHES)) &&
                  (fwd_limit_r != 16'd0) && (bwd_limit_r != 16'd0);

  assign accept    = in_ch.valid && in_ch.ready;
  assign in_range  = ({1'b0, in_ch.microbatch} < num_mb_r);
  assign issuing   = (state_r == ST_SCAN) && (issue_ext < 32'(num_mb_r));
  assign scan_hit  = rd_pend_r && (fwd_run || bwd_run);
  assign scan_miss = !rd_pend_r && !issuing;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  mtp_store #(
    .DEPTH (MAX_MICROBATCHES),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  mtp_eval u_eval (
    .ent        (mem_rdata),
    .cfgv       (cfgv),
    .opcode     (op_r),
    .phase      (phase_r),
    .step_index (k_r),
    .waiting    (wait_r),
    .ent_nxt    (ent_nxt),
    .status     (ev_status),
    .fwd_run    (fwd_run),
    .bwd_run    (bwd_run)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_idx_r == LAST_ADDR) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          priority if (!cfg_ok)                state_nxt = ST_DONE;
          else if (in_ch.opcode == OP_PICK)    state_nxt = ST_SCAN;
          else if (in_range)                   state_nxt = ST_EXEC;
          else                                 state_nxt = ST_DONE;
        end
      end
      ST_EXEC: state_nxt = ST_DONE;
      ST_SCAN: if (scan_hit || scan_miss) state_nxt = ST_DONE;
      ST_DONE: if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ch.ready = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = mb_r_ext[AW-1:0];
    mem_wdata   = ent_nxt;
    mem_raddr   = mb_r_ext[AW-1:0];
    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx_r;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        mem_raddr   = in_mb_ext[AW-1:0];
      end
      ST_EXEC: mem_we = 1'b1;
      ST_SCAN: mem_raddr = issue_ext[AW-1:0];
      ST_DONE: mem_we = 1'b0;
      default: mem_we = 1'b0;
    endcase
  end

  // result of an item that finishes at acceptance
  always_comb begin
    res_acc = '0;
    if (!cfg_ok) begin
      res_acc.status = STS_BAD_CFG;
    end else if (in_ch.opcode < OP_PICK && !in_range) begin
      res_acc.status = STS_RANGE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      clr_idx_r     <= '0;
      out_valid_r   <= 1'b0;
      rd_pend_r     <= 1'b0;
      issue_idx_r   <= '0;
      num_stages_r  <= 9'd1;
      stage_index_r <= 8'd0;
      num_mb_r      <= 7'd8;
      fwd_limit_r   <= 16'd1;
      bwd_limit_r   <= 16'd1;
    end else begin
      state_r <= state_nxt;

      if (state_r == ST_CLEAR) clr_idx_r <= clr_idx_r + AW'(1);

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_NUM_STAGES:  num_stages_r  <= cfg_wdata[8:0];
          CFG_STAGE_INDEX: stage_index_r <= cfg_wdata[7:0];
          CFG_NUM_MB:      num_mb_r      <= cfg_wdata[6:0];
          CFG_FWD_LIMIT:   fwd_limit_r   <= cfg_wdata;
          CFG_BWD_LIMIT:   bwd_limit_r   <= cfg_wdata;
          default:         num_mb_r      <= num_mb_r;
        endcase
      end

      if (accept) begin
        issue_idx_r <= '0;
        rd_pend_r   <= 1'b0;
      end else if (state_r == ST_SCAN) begin
        if (issuing) issue_idx_r <= issue_idx_r + CW'(1);
        rd_pend_r <= issuing;
      end

      if (out_load)          out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // item latch and result assembly
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_ch.opcode;
      mb_r    <= in_ch.microbatch;
      phase_r <= in_ch.phase;
      k_r     <= in_ch.step_index;
      wait_r  <= in_ch.waiting;
      res_r   <= res_acc;
    end

    if (state_r == ST_SCAN) begin
      rd_idx_r <= issue_idx_r;
      if (scan_hit) begin
        res_r.found             <= 1'b1;
        res_r.pick_phase        <= !fwd_run;
        res_r.pick_microbatch   <= rd_idx_ext[5:0];
        res_r.pick_step         <= fwd_run ? mem_rdata.fcnt : mem_rdata.bcnt;
        res_r.fwd_finished_flag <= mem_rdata.ffin;
        res_r.bwd_finished_flag <= mem_rdata.bfin;
      end
    end

    if (state_r == ST_EXEC) begin
      res_r.status            <= (op_r > OP_PICK) ? STS_OK : ev_status;
      res_r.fwd_finished_flag <= ent_nxt.ffin;
      res_r.bwd_finished_flag <= ent_nxt.bfin;
    end

    if (out_load) out_r <= res_r;
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.status            = out_r.status;
  assign out_ch.found             = out_r.found;
  assign out_ch.pick_phase        = out_r.pick_phase;
  assign out_ch.pick_microbatch   = out_r.pick_microbatch;
  assign out_ch.pick_step         = out_r.pick_step;
  assign out_ch.fwd_finished_flag = out_r.fwd_finished_flag;
  assign out_ch.bwd_finished_flag = out_r.bwd_finished_flag;

endmodule

// ===== verif/microbatch_task_picker_unit_tb.sv =====
// self-checking testbench of the microbatch task picker with its own scheduler model
`timescale 1ns / 1ps

module microbatch_task_picker_unit_tb;
  import mtp_pkg::*;

  localparam int MB_SLOTS = 64;
  localparam int SETTLE_CYCLES = MB_SLOTS + 16;
  localparam logic [2:0] OP_RSVD_FIRST = 3'd5;
  localparam logic [2:0] OP_RSVD_MID = 3'd6;
  localparam logic [2:0] OP_RSVD_LAST = 3'd7;
  localparam logic [1:0] PH_UPDATE = 2'd2;
  localparam logic [1:0] PH_RSVD = 2'd3;

  typedef struct packed {
    logic [2:0]  op;
    logic [5:0]  mb;
    logic [1:0]  ph;
    logic [15:0] step;
    logic        wait_flag;
  } sched_req_t;

  logic clk = 1'b0;
  logic rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;

  mtp_in_if in_ch ();
  mtp_out_if out_ch ();

  microbatch_task_picker_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // scheduler model state
  logic [8:0]  cfg_stages;
  logic [7:0]  cfg_stage;
  logic [6:0]  cfg_mb_count;
  logic [15:0] cfg_fwd_lim;
  logic [15:0] cfg_bwd_lim;
  logic        mb_act      [MB_SLOTS];
  logic        mb_grad     [MB_SLOTS];
  logic [15:0] mb_fwd_cnt  [MB_SLOTS];
  logic [15:0] mb_bwd_cnt  [MB_SLOTS];
  logic        mb_fwd_wait [MB_SLOTS];
  logic        mb_bwd_wait [MB_SLOTS];
  logic        mb_fwd_fin  [MB_SLOTS];
  logic        mb_bwd_fin  [MB_SLOTS];

  res_t awaited_results[$];
  res_t last_outcome;
  int   fail_count = 0;
  int   burst_left = 0;
  bit   tx_paced = 1'b1;
  bit   rx_steady = 1'b0;
  int   rx_hold_cycles = 0;
  int   rx_span = 0;
  int   rx_kind = 0;

  always begin
    #10 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic bit cfg_usable();
    return cfg_stages != 9'd0 && {1'b0, cfg_stage} < cfg_stages && cfg_mb_count != 7'd0 &&
           cfg_mb_count <= 7'(MB_SLOTS) && cfg_fwd_lim != 16'd0 && cfg_bwd_lim != 16'd0;
  endfunction

  function automatic bit on_last_stage();
    return ({1'b0, cfg_stage} + 9'd1) == cfg_stages;
  endfunction

  function automatic bit fwd_runnable(input int i);
    return (mb_act[i] || cfg_stage == 8'd0) && !mb_fwd_fin[i] && !mb_fwd_wait[i] &&
           mb_fwd_cnt[i] < cfg_fwd_lim;
  endfunction

  function automatic bit bwd_runnable(input int i);
    return mb_fwd_fin[i] && (on_last_stage() || mb_grad[i]) && !mb_bwd_fin[i] &&
           !mb_bwd_wait[i] && mb_bwd_cnt[i] < cfg_bwd_lim;
  endfunction

  // applies one item to the model and returns the result it must produce
  function automatic res_t scheduler_outcome(input sched_req_t r);
    res_t        o;
    logic        in_rng;
    logic        is_bwd;
    logic        wt;
    logic [15:0] cur;
    logic [15:0] lim;
    int          i;
    o = '0;
    in_rng = {1'b0, r.mb} < cfg_mb_count;
    if (!cfg_usable()) begin
      o.status = STS_BAD_CFG;
    end else if (r.op == OP_PICK) begin
      for (i = 0; i < int'(cfg_mb_count); i++) begin
        if (fwd_runnable(i)) begin
          o.found = 1'b1;
          o.pick_phase = 1'b0;
          o.pick_microbatch = 6'(i);
          o.pick_step = mb_fwd_cnt[i];
          break;
        end
        if (bwd_runnable(i)) begin
          o.found = 1'b1;
          o.pick_phase = 1'b1;
          o.pick_microbatch = 6'(i);
          o.pick_step = mb_bwd_cnt[i];
          break;
        end
      end
      if (o.found) begin
        o.fwd_finished_flag = mb_fwd_fin[o.pick_microbatch];
        o.bwd_finished_flag = mb_bwd_fin[o.pick_microbatch];
      end
    end else if (r.op > OP_PICK) begin
      if (in_rng) begin
        o.fwd_finished_flag = mb_fwd_fin[r.mb];
        o.bwd_finished_flag = mb_bwd_fin[r.mb];
      end
    end else if (!in_rng) begin
      o.status = STS_RANGE;
    end else if (r.op == OP_ACT) begin
      mb_act[r.mb] = 1'b1;
    end else if (r.op == OP_GRAD) begin
      mb_grad[r.mb] = 1'b1;
    end else if (r.ph > PH_BWD) begin
      o.status = STS_UPDATE;
    end else begin
      is_bwd = (r.ph == PH_BWD);
      cur = is_bwd ? mb_bwd_cnt[r.mb] : mb_fwd_cnt[r.mb];
      wt = is_bwd ? mb_bwd_wait[r.mb] : mb_fwd_wait[r.mb];
      lim = is_bwd ? cfg_bwd_lim : cfg_fwd_lim;
      if (r.step != cur) begin
        o.status = STS_STEP;
      end else if (r.op == OP_WAIT) begin
        if (is_bwd) mb_bwd_wait[r.mb] = r.wait_flag;
        else mb_fwd_wait[r.mb] = r.wait_flag;
      end else if (wt) begin
        o.status = STS_WAITING;
      end else begin
        // counter sticks at its maximum, done flag stays set on later steps
        if (cur != CNT_MAX) cur = cur + 16'd1;
        if (is_bwd) mb_bwd_cnt[r.mb] = cur;
        else mb_fwd_cnt[r.mb] = cur;
        if (cur >= lim) begin
          if (is_bwd) begin
            mb_bwd_fin[r.mb] = 1'b1;
          end else begin
            mb_fwd_fin[r.mb] = 1'b1;
            if (on_last_stage()) mb_grad[r.mb] = 1'b1;
          end
        end
      end
    end
    if (r.op < OP_PICK && in_rng && o.status != STS_BAD_CFG) begin
      o.fwd_finished_flag = mb_fwd_fin[r.mb];
      o.bwd_finished_flag = mb_bwd_fin[r.mb];
    end
    return o;
  endfunction

  task automatic send_item(input logic [2:0] op, input logic [5:0] mb, input logic [1:0] ph,
                           input logic [15:0] step, input logic wait_flag);
    int         gap;
    sched_req_t r;
    if (tx_paced && burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    r = '{op: op, mb: mb, ph: ph, step: step, wait_flag: wait_flag};
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.microbatch <= mb;
    in_ch.phase <= ph;
    in_ch.step_index <= step;
    in_ch.waiting <= wait_flag;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
    last_outcome = scheduler_outcome(r);
    awaited_results = {awaited_results, last_outcome};
  endtask

  // sender pauses until every result is back, then lets the block settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_NUM_STAGES:  cfg_stages = val[8:0];
      CFG_STAGE_INDEX: cfg_stage = val[7:0];
      CFG_NUM_MB:      cfg_mb_count = val[6:0];
      CFG_FWD_LIMIT:   cfg_fwd_lim = val;
      CFG_BWD_LIMIT:   cfg_bwd_lim = val;
      default: ;
    endcase
  endtask

  task automatic load_config(input int stages, input int stage, input int mbs,
                             input int fwd_lim, input int bwd_lim);
    drain();
    write_reg(CFG_NUM_STAGES, 16'(stages));
    write_reg(CFG_STAGE_INDEX, 16'(stage));
    write_reg(CFG_NUM_MB, 16'(mbs));
    write_reg(CFG_FWD_LIMIT, 16'(fwd_lim));
    write_reg(CFG_BWD_LIMIT, 16'(bwd_lim));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [5:0] target_mb();
    if ($urandom_range(0, 7) == 0) return 6'($urandom_range(0, 63));
    return 6'($urandom_range(0, int'(cfg_mb_count) - 1));
  endfunction

  task automatic run_traffic(input int count);
    int          n;
    int          choice;
    logic [5:0]  mb;
    logic [1:0]  ph;
    logic [15:0] cur;
    n = 0;
    while (n < count) begin
      choice = $urandom_range(0, 99);
      mb = target_mb();
      ph = 2'($urandom_range(0, 1));
      cur = (ph == PH_BWD) ? mb_bwd_cnt[mb] : mb_fwd_cnt[mb];
      if (choice < 30) begin
        send_item(OP_PICK, 6'($urandom), 2'($urandom), 16'($urandom), 1'($urandom));
        n++;
        // mostly run the picked task to keep the schedule moving
        if (last_outcome.found && $urandom_range(0, 4) != 0 && n < count) begin
          send_item(OP_DONE, last_outcome.pick_microbatch, {1'b0, last_outcome.pick_phase},
                    last_outcome.pick_step, 1'($urandom));
          n++;
        end
      end else if (choice < 42) begin
        send_item(OP_ACT, mb, ph, 16'($urandom), 1'($urandom));
        n++;
      end else if (choice < 52) begin
        send_item(OP_GRAD, mb, ph, 16'($urandom), 1'($urandom));
        n++;
      end else if (choice < 64) begin
        send_item(OP_WAIT, mb, ph, cur, 1'($urandom));
        n++;
      end else if (choice < 88) begin
        send_item(OP_DONE, mb, ph, cur, 1'($urandom));
        n++;
      end else begin
        send_item(3'($urandom_range(OP_ACT, OP_RSVD_LAST)), 6'($urandom),
                  2'($urandom_range(PH_FWD, PH_RSVD)), 16'($urandom), 1'($urandom));
        n++;
      end
    end
  endtask

  task automatic test_directed();
    // reset settings: single stage, eight microbatches
    send_item(OP_PICK, 6'd0, PH_FWD, 16'd0, 1'b0);
    load_config(2, 0, 4, 2, 1);
    send_item(OP_PICK, 6'd63, PH_RSVD, CNT_MAX, 1'b1);
    send_item(OP_ACT, 6'd63, PH_RSVD, CNT_MAX, 1'b1);
    send_item(OP_ACT, 6'd1, PH_FWD, 16'd0, 1'b0);
    send_item(OP_GRAD, 6'd1, PH_FWD, 16'd0, 1'b0);
    send_item(OP_WAIT, 6'd0, PH_FWD, 16'd0, 1'b1);
    send_item(OP_PICK, 6'd0, PH_FWD, 16'd0, 1'b0);
    send_item(OP_DONE, 6'd0, PH_FWD, 16'd0, 1'b0);
    send_item(OP_WAIT, 6'd0, PH_FWD, 16'd0, 1'b0);
    send_item(OP_DONE, 6'd0, PH_FWD, 16'd5, 1'b0);
    send_item(OP_DONE, 6'd1, PH_UPDATE, 16'd0, 1'b0);
    send_item(OP_WAIT, 6'd1, PH_RSVD, 16'd0, 1'b1);
    send_item(OP_DONE, 6'd0, PH_FWD, 16'd0, 1'b0);
    send_item(OP_DONE, 6'd0, PH_FWD, 16'd1, 1'b0);
    // done again on a finished phase still advances the counter
    send_item(OP_DONE, 6'd0, PH_FWD, 16'd2, 1'b0);
    send_item(OP_PICK, 6'd0, PH_FWD, 16'd0, 1'b0);
    send_item(OP_GRAD, 6'd0, PH_FWD, 16'd0, 1'b0);
    send_item(OP_PICK, 6'd0, PH_FWD, 16'd0, 1'b0);
    send_item(OP_DONE, 6'd0, PH_BWD, 16'd0, 1'b0);
    send_item(OP_RSVD_FIRST, 6'd0, PH_FWD, 16'd0, 1'b0);
    send_item(OP_RSVD_LAST, 6'd5, PH_BWD, 16'd0, 1'b1);
    send_item(OP_RSVD_MID, 6'd63, PH_UPDATE, CNT_MAX, 1'b0);
  endtask

  task automatic test_bad_config();
    load_config(0, 0, 8, 1, 1);
    send_item(OP_PICK, 6'd0, PH_FWD, 16'd0, 1'b0);
    load_config(3, 3, 8, 1, 1);
    send_item(OP_DONE, 6'd0, PH_FWD, 16'd0, 1'b0);
    load_config(511, 0, 0, 1, 1);
    send_item(OP_ACT, 6'd0, PH_FWD, 16'd0, 1'b0);
    load_config(1, 0, MB_SLOTS + 1, 1, 1);
    send_item(OP_PICK, 6'd0, PH_FWD, 16'd0, 1'b0);
    load_config(1, 0, 127, 1, 1);
    send_item(OP_WAIT, 6'd0, PH_FWD, 16'd0, 1'b1);
    load_config(1, 0, 8, 0, 1);
    send_item(OP_DONE, 6'd0, PH_FWD, 16'd0, 1'b0);
    load_config(1, 0, 8, 1, 0);
    send_item(OP_PICK, 6'd0, PH_FWD, 16'd0, 1'b0);
  endtask

  task automatic test_random_phases();
    int stages;
    load_config(1, 0, 8, 2, 2);
    run_traffic(150);
    load_config(4, 0, $urandom_range(1, 12), $urandom_range(1, 3), $urandom_range(1, 3));
    run_traffic(150);
    load_config(4, 3, $urandom_range(1, 12), $urandom_range(1, 3), $urandom_range(1, 3));
    run_traffic(150);
    load_config(5, 2, $urandom_range(1, 16), $urandom_range(1, 3), $urandom_range(1, 3));
    run_traffic(150);
    // widest settings: last of 256 stages, every microbatch, largest limits
    load_config(256, 255, MB_SLOTS, 16'hFFFF, 16'hFFFF);
    run_traffic(100);
    load_config(256, 255, MB_SLOTS, 1, 1);
    run_traffic(100);
    stages = $urandom_range(1, 8);
    load_config(stages, $urandom_range(0, stages - 1), 1, $urandom_range(1, 3), 16'hFFFF);
    run_traffic(100);
  endtask

  task automatic test_backpressure();
    load_config(1, 0, 8, 3, 3);
    rx_hold_cycles = 300;
    run_traffic(24);
    drain();
  endtask

  task automatic test_done_again();
    load_config(1, 0, 1, 1, 1);
    tx_paced = 1'b0;
    rx_steady = 1'b1;
    // counters keep advancing past the limit while the done flags stay set
    send_item(OP_WAIT, 6'd0, PH_FWD, mb_fwd_cnt[0], 1'b0);
    repeat (6) send_item(OP_DONE, 6'd0, PH_FWD, mb_fwd_cnt[0], 1'b0);
    send_item(OP_DONE, 6'd0, PH_FWD, 16'd0, 1'b0);
    send_item(OP_PICK, 6'd0, PH_FWD, 16'd0, 1'b0);
    send_item(OP_WAIT, 6'd0, PH_BWD, mb_bwd_cnt[0], 1'b0);
    repeat (4) send_item(OP_DONE, 6'd0, PH_BWD, mb_bwd_cnt[0], 1'b0);
    send_item(OP_PICK, 6'd0, PH_FWD, 16'd0, 1'b0);
    tx_paced = 1'b1;
    rx_steady = 1'b0;
  endtask

  // receiver: random stall stretches, an optional long hold, or always ready
  always @(posedge clk) begin
    if (rx_hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      rx_hold_cycles--;
    end else if (rx_steady) begin
      out_ch.ready <= 1'b1;
    end else begin
      if (rx_span <= 0) begin
        rx_span = $urandom_range(1, 40);
        rx_kind = $urandom_range(0, 3);
      end
      rx_span--;
      out_ch.ready <= (rx_kind == 0) || ($urandom_range(0, rx_kind) == 0);
    end
  end

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (awaited_results.size() == 0) begin
        $error("result item with nothing expected");
        fail_count++;
      end else begin
        want = awaited_results.pop_front();
        compare_field("status", want.status, out_ch.status);
        compare_field("found", want.found, out_ch.found);
        compare_field("pick_phase", want.pick_phase, out_ch.pick_phase);
        compare_field("pick_microbatch", want.pick_microbatch, out_ch.pick_microbatch);
        compare_field("pick_step", want.pick_step, out_ch.pick_step);
        compare_field("fwd_finished_flag", want.fwd_finished_flag, out_ch.fwd_finished_flag);
        compare_field("bwd_finished_flag", want.bwd_finished_flag, out_ch.bwd_finished_flag);
      end
    end
  end

  initial begin
    int i;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_NUM_STAGES;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.opcode <= OP_ACT;
    in_ch.microbatch <= '0;
    in_ch.phase <= PH_FWD;
    in_ch.step_index <= '0;
    in_ch.waiting <= 1'b0;
    cfg_stages = 9'd1;
    cfg_stage = 8'd0;
    cfg_mb_count = 7'd8;
    cfg_fwd_lim = 16'd1;
    cfg_bwd_lim = 16'd1;
    for (i = 0; i < MB_SLOTS; i++) begin
      mb_act[i] = 1'b0;
      mb_grad[i] = 1'b0;
      mb_fwd_cnt[i] = '0;
      mb_bwd_cnt[i] = '0;
      mb_fwd_wait[i] = 1'b0;
      mb_bwd_wait[i] = 1'b0;
      mb_fwd_fin[i] = 1'b0;
      mb_bwd_fin[i] = 1'b0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    // covers the clearing pass after reset
    drain();
    test_directed();
    test_bad_config();
    test_random_phases();
    test_backpressure();
    test_done_again();
    drain();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/mtp_pkg.sv
design/mtp_if.sv
design/mtp_store.sv
design/mtp_eval.sv
design/microbatch_task_picker_unit.sv
verif/microbatch_task_picker_unit_tb.sv
